// ----- rtl/tccb_pkg.sv -----
`default_nettype none

package tccb_pkg;

    // Store geometry. The column count is a power of two, so a cell address
    // is the row index above the column index.
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int PTR_W    = ADDR_W + 1;

    // Configuration register widths and indexes.
    localparam int ROWS_REG_W = 6;
    localparam int COLS_REG_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Stream payload widths.
    localparam int KIND_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERASE = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;

endpackage

`default_nettype wire

// ----- rtl/text_console_cursor_buffer.sv -----
// Each item passes through the execute and result steps before its result is registered
// on the master side; a newline on the last row adds the row copy and bottom-row clear,
// and a clear item adds a pass over all 4096 cells (one cell a cycle). The slave side
// takes no new item until the previous item's result is registered; a stalled master side holds it.
// Reset (synchronous, active low) homes the cursor and sets both size registers to
// full size, then runs a clearing pass over all 4096 cells of the cell memory before s_tready rises.
`default_nettype none

module text_console_cursor_buffer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [tccb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Slave side.
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // s_tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero pad.
    input  wire logic [tccb_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: kind[2:0].
    input  wire logic [tccb_pkg::KIND_W-1:0]       s_tuser,
    // Master side.
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: cell_char[7:0], cursor_row[12:8], cursor_col[19:13], zero pad.
    output      logic [tccb_pkg::M_DATA_W-1:0]     m_tdata
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_ZERO,
        ST_RESULT
    } t_state;

    t_state r_state;

    logic [tccb_pkg::ROWS_REG_W-1:0] r_rows;
    logic [tccb_pkg::COLS_REG_W-1:0] r_cols;
    logic [tccb_pkg::ROW_W-1:0]      r_row;
    logic [tccb_pkg::COL_W-1:0]      r_col;

    logic [tccb_pkg::KIND_W-1:0]     r_kind;
    logic [tccb_pkg::CHAR_W-1:0]     r_code;
    logic [tccb_pkg::ROW_W-1:0]      r_rrow;
    logic [tccb_pkg::COL_W-1:0]      r_rcol;
    logic                            r_rd_sel;

    logic [tccb_pkg::PTR_W-1:0]      r_ptr;
    logic [tccb_pkg::PTR_W-1:0]      r_end;
    logic [tccb_pkg::ADDR_W-1:0]     r_waddr;
    logic                            r_wpend;

    logic                            r_out_valid;
    logic [tccb_pkg::M_DATA_W-1:0]   r_out_data;

    logic [tccb_pkg::CHAR_W-1:0]     mem [tccb_pkg::DEPTH];
    logic [tccb_pkg::CHAR_W-1:0]     r_rdata;

    logic                            mem_we;
    logic [tccb_pkg::ADDR_W-1:0]     mem_waddr;
    logic [tccb_pkg::CHAR_W-1:0]     mem_wdata;
    logic                            mem_re;
    logic [tccb_pkg::ADDR_W-1:0]     mem_raddr;

    logic [tccb_pkg::ROWS_REG_W-1:0] eff_rows;
    logic [tccb_pkg::COLS_REG_W-1:0] eff_cols;
    logic [tccb_pkg::ROWS_REG_W-1:0] cfg_rows;
    logic [tccb_pkg::COLS_REG_W-1:0] cfg_cols;
    logic                            on_last_row;
    logic                            col_can_step;
    logic [tccb_pkg::COL_W-1:0]      col_left;
    logic                            read_in_range;
    logic                            is_ctrl;
    logic [tccb_pkg::PTR_W-1:0]      rows_end;
    logic                            s_xfer;

    function automatic logic [tccb_pkg::ROWS_REG_W-1:0] sat_rows(
        input logic [tccb_pkg::ROWS_REG_W-1:0] v
    );
        logic [tccb_pkg::ROWS_REG_W-1:0] res;
        if (v == '0) begin
            res = tccb_pkg::ROWS_REG_W'(1);
        end else if (v > tccb_pkg::ROWS_REG_W'(tccb_pkg::MAX_ROWS)) begin
            res = tccb_pkg::ROWS_REG_W'(tccb_pkg::MAX_ROWS);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [tccb_pkg::COLS_REG_W-1:0] sat_cols(
        input logic [tccb_pkg::COLS_REG_W-1:0] v
    );
        logic [tccb_pkg::COLS_REG_W-1:0] res;
        if (v == '0) begin
            res = tccb_pkg::COLS_REG_W'(1);
        end else if (v > tccb_pkg::COLS_REG_W'(tccb_pkg::MAX_COLS)) begin
            res = tccb_pkg::COLS_REG_W'(tccb_pkg::MAX_COLS);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign eff_rows = sat_rows(r_rows);
    assign eff_cols = sat_cols(r_cols);
    assign cfg_rows = sat_rows(i_cfg_data[tccb_pkg::ROWS_REG_W-1:0]);
    assign cfg_cols = sat_cols(i_cfg_data[tccb_pkg::COLS_REG_W-1:0]);

    assign on_last_row   = ({1'b0, r_row} + tccb_pkg::ROWS_REG_W'(1)) >= eff_rows;
    assign col_can_step  = ({1'b0, r_col} + tccb_pkg::COLS_REG_W'(1)) < eff_cols;
    assign col_left      = (r_col != '0) ? r_col - tccb_pkg::COL_W'(1) : r_col;
    assign read_in_range = ({1'b0, r_rrow} < eff_rows) && ({1'b0, r_rcol} < eff_cols);
    assign is_ctrl       = (r_code == tccb_pkg::CH_NEWLINE) || (r_code == tccb_pkg::CH_RETURN)
                        || (r_code == tccb_pkg::CH_BACKSPACE);
    assign rows_end      = tccb_pkg::PTR_W'(eff_rows) << tccb_pkg::COL_W;

    assign s_tready = (r_state == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // Memory port control. During a scroll the read runs one cell ahead of the
    // write, which lands one row up, so the two never touch the same cell.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_row, r_col};
        mem_wdata = tccb_pkg::CH_NUL;
        mem_re    = 1'b0;
        mem_raddr = {r_rrow, r_rcol};
        case (r_state)
            ST_INIT, ST_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[tccb_pkg::ADDR_W-1:0];
            end
            ST_SCROLL: begin
                mem_we    = r_wpend;
                mem_waddr = r_waddr;
                mem_wdata = r_rdata;
                mem_re    = (r_ptr != r_end);
                mem_raddr = r_ptr[tccb_pkg::ADDR_W-1:0];
            end
            ST_EXEC: begin
                if (r_kind == tccb_pkg::KIND_PUT && !is_ctrl) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_code;
                end else if (r_kind == tccb_pkg::KIND_ERASE) begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_row, col_left};
                end else if (r_kind == tccb_pkg::KIND_READ) begin
                    mem_re = read_in_range;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_rows      <= tccb_pkg::ROWS_REG_W'(tccb_pkg::MAX_ROWS);
            r_cols      <= tccb_pkg::COLS_REG_W'(tccb_pkg::MAX_COLS);
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_end       <= tccb_pkg::PTR_W'(tccb_pkg::DEPTH);
            r_wpend     <= 1'b0;
            r_rd_sel    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end

            // The cursor is pulled into the new active area on a write, unless a command moves it in the same cycle.
            if (i_cfg_we) begin
                if (i_cfg_idx == tccb_pkg::REG_ROWS) begin
                    r_rows <= i_cfg_data[tccb_pkg::ROWS_REG_W-1:0];
                    if ({1'b0, r_row} >= cfg_rows) begin
                        r_row <= tccb_pkg::ROW_W'(cfg_rows - tccb_pkg::ROWS_REG_W'(1));
                    end
                end else begin
                    r_cols <= i_cfg_data;
                    if ({1'b0, r_col} >= cfg_cols) begin
                        r_col <= tccb_pkg::COL_W'(cfg_cols - tccb_pkg::COLS_REG_W'(1));
                    end
                end
            end

            case (r_state)
                ST_INIT: begin
                    r_ptr <= r_ptr + tccb_pkg::PTR_W'(1);
                    if (r_ptr + tccb_pkg::PTR_W'(1) == r_end) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_xfer) begin
                        r_kind  <= s_tuser;
                        r_code  <= s_tdata[7:0];
                        r_rrow  <= s_tdata[12:8];
                        r_rcol  <= s_tdata[19:13];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_rd_sel <= 1'b0;
                    r_state  <= ST_RESULT;
                    case (r_kind)
                        tccb_pkg::KIND_PUT: begin
                            if (r_code == tccb_pkg::CH_NEWLINE) begin
                                r_col <= '0;
                                if (on_last_row) begin
                                    r_ptr   <= tccb_pkg::PTR_W'(tccb_pkg::MAX_COLS);
                                    r_end   <= rows_end;
                                    r_wpend <= 1'b0;
                                    r_state <= ST_SCROLL;
                                end else begin
                                    r_row <= r_row + tccb_pkg::ROW_W'(1);
                                end
                            end else if (r_code == tccb_pkg::CH_RETURN) begin
                                r_col <= '0;
                            end else if (r_code == tccb_pkg::CH_BACKSPACE) begin
                                r_col <= col_left;
                            end else if (col_can_step) begin
                                r_col <= r_col + tccb_pkg::COL_W'(1);
                            end
                        end
                        tccb_pkg::KIND_READ: begin
                            r_rd_sel <= read_in_range;
                        end
                        tccb_pkg::KIND_CLEAR: begin
                            r_ptr   <= '0;
                            r_end   <= tccb_pkg::PTR_W'(tccb_pkg::DEPTH);
                            r_state <= ST_ZERO;
                        end
                        tccb_pkg::KIND_HOME: begin
                            r_row <= '0;
                            r_col <= '0;
                        end
                        tccb_pkg::KIND_ERASE: begin
                            r_col <= col_left;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SCROLL: begin
                    if (r_ptr != r_end) begin
                        r_waddr <= r_ptr[tccb_pkg::ADDR_W-1:0]
                                 - tccb_pkg::ADDR_W'(tccb_pkg::MAX_COLS);
                        r_wpend <= 1'b1;
                        r_ptr   <= r_ptr + tccb_pkg::PTR_W'(1);
                    end else begin
                        // Last copy is written this cycle; then blank the bottom row.
                        r_wpend <= 1'b0;
                        r_ptr   <= r_end - tccb_pkg::PTR_W'(tccb_pkg::MAX_COLS);
                        r_state <= ST_ZERO;
                    end
                end
                ST_ZERO: begin
                    r_ptr <= r_ptr + tccb_pkg::PTR_W'(1);
                    if (r_ptr + tccb_pkg::PTR_W'(1) == r_end) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!r_out_valid || m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'b0, r_col, r_row,
                                        r_rd_sel ? r_rdata : tccb_pkg::CH_NUL};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tccb_checker.sv -----
`default_nettype none

module tccb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tccb_pkg::M_DATA_W-1:0] m_tdata
);

    // A held result keeps its payload until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: the slave side closes right after a transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // A new result only follows a cycle in which the block was busy.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in work");

    // Reset closes both sides while the memory is cleared.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && !s_tready)
        else $error("stream open right after reset");

endmodule

bind text_console_cursor_buffer tccb_checker u_tccb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
